// File: design/khs_pkg.sv
package khs_pkg;

  localparam int unsigned TableSize = 2011;
  localparam int unsigned MaxK = 8;
  localparam int unsigned AddrW = $clog2(TableSize);
  localparam int unsigned WordW = 8 * MaxK;
  localparam int unsigned ProbeW = $clog2(TableSize + 1);

  localparam logic [1:0] KindTextA = 2'd0;
  localparam logic [1:0] KindTextB = 2'd1;
  localparam logic [1:0] KindQuery = 2'd2;
  localparam logic [1:0] KindNone = 2'd3;

  localparam logic [2:0] StQuery = 3'd0;
  localparam logic [2:0] StNotFull = 3'd1;
  localparam logic [2:0] StStored = 3'd2;
  localparam logic [2:0] StPresent = 3'd3;
  localparam logic [2:0] StDropped = 3'd4;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] text_char;
    logic text_last;
    logic [63:0] query_key;
  } in_item_t;

  typedef struct packed {
    logic [1:0] membership;
    logic [2:0] status;
  } out_item_t;

  // controller to datapath
  typedef struct packed {
    logic load;        // capture item, shift window
    logic hash_init;
    logic hash_step;
    logic probe_init;  // pos <= hash, j <= 1
    logic rd;          // issue table read at pos
    logic adv;         // advance probe position
    logic wr;          // write word at pos
    logic sel_b;       // table select
    logic win_clear;
    logic clr_step;    // clearing sweep
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic hash_done;
    logic full;        // window has k chars
    logic is_free;
    logic is_hit;
    logic probe_end;   // TableSize probes spent
    logic clr_done;
    logic [1:0] kind;
  } dp_sts_t;

endpackage

// File: design/kmer_hash_set_quadratic_probe_core.sv
// Two open-addressed hash sets of k-character words with quadratic probing. Text
// characters for set A or B shift into a window; each full window is hashed one
// character per step and then probed, one table read per probe, until a free or
// matching slot or until the probe limit is spent (queries probe both sets).
// One transaction is in flight at a time. After reset a clearing sweep of all
// table slots runs before the first input is accepted.
module kmer_hash_set_quadratic_probe_core (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  khs_pkg::in_item_t    in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output khs_pkg::out_item_t   out_data_o,
  input  logic                 cfg_we_i,
  input  logic [3:0]           cfg_wdata_i
);

  logic [3:0] k_length_q;
  khs_pkg::dp_cmd_t cmd;
  khs_pkg::dp_sts_t sts;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) k_length_q <= 4'd8;
    else if (cfg_we_i) k_length_q <= cfg_wdata_i;
  end

  khs_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o,
    .item_i(in_data_i), .out_valid_o, .out_ready_i,
    .out_o(out_data_o), .cmd_o(cmd), .sts_i(sts)
  );

  khs_datapath u_dp (
    .clk_i, .rst_ni, .item_i(in_data_i), .k_length_i(k_length_q),
    .cmd_i(cmd), .sts_o(sts)
  );

endmodule

// File: design/khs_datapath.sv
module khs_datapath (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  khs_pkg::in_item_t    item_i,
  input  logic [3:0]           k_length_i,
  input  khs_pkg::dp_cmd_t     cmd_i,
  output khs_pkg::dp_sts_t     sts_o
);

  localparam int unsigned AW = khs_pkg::AddrW;
  localparam int unsigned WW = khs_pkg::WordW;
  localparam int unsigned PW = khs_pkg::ProbeW;
  localparam logic [AW-1:0] TS = AW'(khs_pkg::TableSize);

  logic [WW:0] mem_a [khs_pkg::TableSize];
  logic [WW:0] mem_b [khs_pkg::TableSize];
  logic [WW:0] rd_a_q, rd_b_q;

  logic [1:0] kind_q;
  logic [WW-1:0] qkey_q;
  logic [WW-1:0] win_q, win_d;
  logic [3:0] fill_q, fill_d;
  logic [3:0] keff;
  logic [WW-1:0] word_q, word_d;
  logic [AW-1:0] hash_q;
  logic [3:0] hcnt_q;
  logic [AW-1:0] pos_q;
  logic [PW-1:0] j_q;
  logic [AW-1:0] clr_q;
  logic clr_done_q;
  logic [WW:0] rd_sel;
  logic [AW+6:0] hmul;
  logic [AW+6:0] hred;
  logic [7:0] hchar;
  logic [AW+1:0] pnext;
  logic [AW+1:0] pwrap;

  always_comb begin
    keff = k_length_i;
    if (keff == 4'd0) keff = 4'd1;
    if (keff > 4'(khs_pkg::MaxK)) keff = 4'(khs_pkg::MaxK);
  end

  // masked word for the current item
  always_comb begin
    logic [WW-1:0] src;
    logic [WW-1:0] msk;
    msk = '0;
    for (int i = 0; i < khs_pkg::MaxK; i++) begin
      if (4'(i) < keff) msk[8*i +: 8] = 8'hff;
    end
    if (kind_q == khs_pkg::KindQuery) src = qkey_q;
    else src = win_q >> (8 * (4'(khs_pkg::MaxK) - keff));
    word_d = src & msk;
  end

  // one hash character per step, product below 38*TableSize + 255
  assign hchar = word_q[8*hcnt_q[2:0] +: 8];
  assign hmul = (AW+7)'(hash_q) * (AW+7)'(38) + (AW+7)'(hchar);
  always_comb begin
    hred = hmul;
    for (int i = 0; i < 6; i++) begin
      if (hred >= (AW+7)'(32 * khs_pkg::TableSize) >> i)
        hred = hred - ((AW+7)'(32 * khs_pkg::TableSize) >> i);
    end
  end

  // pos plus step 2j-1 can reach past twice the table size
  assign pnext = (AW+2)'(pos_q) + (AW+2)'({j_q, 1'b0}) - (AW+2)'(1);
  assign pwrap = (pnext >= (AW+2)'(2 * khs_pkg::TableSize)) ?
                 pnext - (AW+2)'(2 * khs_pkg::TableSize) : pnext;

  always_comb begin
    win_d = win_q;
    fill_d = fill_q;
    if (cmd_i.load && (item_i.kind == khs_pkg::KindTextA ||
                       item_i.kind == khs_pkg::KindTextB)) begin
      win_d = {item_i.text_char, win_q[WW-1:8]};
      if (fill_q < 4'(khs_pkg::MaxK)) fill_d = fill_q + 4'd1;
    end
    if (cmd_i.win_clear) begin
      win_d = '0;
      fill_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q <= '0;
      fill_q <= '0;
      clr_q <= '0;
      clr_done_q <= 1'b0;
      kind_q <= '0;
    end else begin
      win_q <= win_d;
      fill_q <= fill_d;
      if (cmd_i.load) kind_q <= item_i.kind;
      if (cmd_i.clr_step) begin
        if (clr_q == TS - AW'(1)) clr_done_q <= 1'b1;
        else clr_q <= clr_q + AW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      qkey_q <= item_i.query_key;
    end
    if (cmd_i.hash_init) begin
      word_q <= word_d;
      hash_q <= '0;
      hcnt_q <= '0;
    end else if (cmd_i.hash_step) begin
      hash_q <= AW'(hred);
      hcnt_q <= hcnt_q + 4'd1;
    end
    if (cmd_i.probe_init) begin
      pos_q <= hash_q;
      j_q <= PW'(1);
    end else if (cmd_i.adv) begin
      pos_q <= (pwrap >= (AW+2)'(khs_pkg::TableSize)) ? AW'(pwrap - (AW+2)'(khs_pkg::TableSize))
                                                       : AW'(pwrap);
      j_q <= j_q + PW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.clr_step) begin
      mem_a[clr_q] <= '0;
    end else if (cmd_i.wr && !cmd_i.sel_b) begin
      mem_a[pos_q] <= {1'b1, word_q};
    end
    if (cmd_i.rd) rd_a_q <= mem_a[pos_q];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.clr_step) begin
      mem_b[clr_q] <= '0;
    end else if (cmd_i.wr && cmd_i.sel_b) begin
      mem_b[pos_q] <= {1'b1, word_q};
    end
    if (cmd_i.rd) rd_b_q <= mem_b[pos_q];
  end

  assign rd_sel = cmd_i.sel_b ? rd_b_q : rd_a_q;

  assign sts_o.hash_done = (hcnt_q == keff);
  assign sts_o.full = (fill_q >= keff);
  assign sts_o.is_free = !rd_sel[WW];
  assign sts_o.is_hit = rd_sel[WW] && (rd_sel[WW-1:0] == word_q);
  assign sts_o.probe_end = (j_q == PW'(khs_pkg::TableSize));
  assign sts_o.clr_done = clr_done_q;
  assign sts_o.kind = kind_q;

endmodule

// File: design/khs_ctrl.sv
module khs_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  khs_pkg::in_item_t    item_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output khs_pkg::out_item_t   out_o,
  output khs_pkg::dp_cmd_t     cmd_o,
  input  khs_pkg::dp_sts_t     sts_i
);

  typedef enum logic [7:0] {
    S_CLEAR = 8'b0000_0001,
    S_IDLE  = 8'b0000_0010,
    S_HASH  = 8'b0000_0100,
    S_READ  = 8'b0000_1000,
    S_CHECK = 8'b0001_0000,
    S_WAIT  = 8'b0010_0000,
    S_NEXTB = 8'b0100_0000,
    S_SKIP  = 8'b1000_0000
  } state_e;

  state_e state_q, state_d;
  logic sel_b_q, sel_b_d;
  logic [1:0] mem_q, mem_d;
  logic last_q, last_d;
  logic [2:0] st_d;
  logic ov_q, ov_d;
  khs_pkg::out_item_t out_q, out_d;
  logic finish;
  logic is_query;

  assign is_query = (sts_i.kind == khs_pkg::KindQuery);
  assign in_ready_o = (state_q == S_IDLE) && !ov_q;
  assign out_valid_o = ov_q;
  assign out_o = out_q;

  always_comb begin
    state_d = state_q;
    sel_b_d = sel_b_q;
    mem_d = mem_q;
    last_d = last_q;
    ov_d = ov_q;
    out_d = out_q;
    cmd_o = '0;
    cmd_o.sel_b = sel_b_q;
    finish = 1'b0;
    st_d = khs_pkg::StQuery;
    if (ov_q && out_ready_i) ov_d = 1'b0;
    unique case (state_q)
      S_CLEAR: begin
        cmd_o.clr_step = !sts_i.clr_done;
        if (sts_i.clr_done) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid_i && in_ready_o) begin
          cmd_o.load = 1'b1;
          sel_b_d = (item_i.kind == khs_pkg::KindTextB);
          last_d = item_i.text_last;
          mem_d = '0;
          state_d = S_SKIP;
        end
      end
      S_SKIP: begin
        // window updated; decide path
        if (sts_i.kind == khs_pkg::KindNone) begin
          finish = 1'b1;
        end else if (!is_query && !sts_i.full) begin
          st_d = khs_pkg::StNotFull;
          finish = 1'b1;
        end else begin
          cmd_o.hash_init = 1'b1;
          state_d = S_HASH;
        end
      end
      S_HASH: begin
        if (sts_i.hash_done) begin
          cmd_o.probe_init = 1'b1;
          state_d = S_READ;
        end else begin
          cmd_o.hash_step = 1'b1;
        end
      end
      S_READ: begin
        cmd_o.rd = 1'b1;
        state_d = S_CHECK;
      end
      S_CHECK: begin
        priority if (sts_i.is_hit) begin
          if (is_query) begin
            mem_d = mem_q | (sel_b_q ? 2'b10 : 2'b01);
            state_d = S_NEXTB;
          end else begin
            st_d = khs_pkg::StPresent;
            finish = 1'b1;
          end
        end else if (sts_i.is_free) begin
          if (is_query) state_d = S_NEXTB;
          else begin
            cmd_o.wr = 1'b1;
            st_d = khs_pkg::StStored;
            finish = 1'b1;
          end
        end else if (sts_i.probe_end) begin
          if (is_query) state_d = S_NEXTB;
          else begin
            st_d = khs_pkg::StDropped;
            finish = 1'b1;
          end
        end else begin
          cmd_o.adv = 1'b1;
          state_d = S_READ;
        end
      end
      S_NEXTB: begin
        if (sel_b_q) begin
          st_d = khs_pkg::StQuery;
          finish = 1'b1;
        end else begin
          sel_b_d = 1'b1;
          cmd_o.probe_init = 1'b1;
          state_d = S_READ;
        end
      end
      S_WAIT: state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
    if (finish) begin
      out_d.membership = mem_d;
      out_d.status = st_d;
      ov_d = 1'b1;
      cmd_o.win_clear = !is_query && (sts_i.kind != khs_pkg::KindNone) && last_q;
      state_d = S_IDLE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      ov_q <= 1'b0;
      sel_b_q <= 1'b0;
      mem_q <= '0;
      last_q <= 1'b0;
    end else begin
      state_q <= state_d;
      ov_q <= ov_d;
      sel_b_q <= sel_b_d;
      mem_q <= mem_d;
      last_q <= last_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("second item taken while busy");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> (out_valid_o && $stable(out_o)))
    else $error("result lost under stall");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CLEAR) |-> !in_ready_o)
    else $error("item taken during clearing sweep");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.wr |-> (state_q == S_CHECK && sts_i.is_free))
    else $error("write without free slot");

endmodule
